// File: hw/rtl/tts_pkg.sv
// Shared types, codes and constants for the timer table scheduler.
package tts_pkg;

  localparam int NOW_W = 48;
  localparam int TMO_W = 40;
  localparam int ID_W  = 31;
  localparam int CNT_W = 5;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int MAX_FIRE        = 16;

  localparam logic [2:0] MODE_SCHED  = 3'd0;
  localparam logic [2:0] MODE_CANCEL = 3'd1;
  localparam logic [2:0] MODE_TICK   = 3'd2;
  localparam logic [2:0] MODE_COUNT  = 3'd3;
  localparam logic [2:0] MODE_SETDL  = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NONE     = 2'd3;

  localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};
  localparam logic [CNT_W-1:0] DUE_SAT = {CNT_W{1'b1}};

  typedef struct packed {
    logic [2:0]       mode;
    logic [NOW_W-1:0] now_us;
    logic [TMO_W-1:0] timeout_us;
    logic             periodic;
    logic [ID_W-1:0]  target_id;
    logic [NOW_W-1:0] new_deadline;
  } tts_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  result_id;
    logic             fired_periodic;
    logic [CNT_W-1:0] due_cnt;
    logic             last;
  } tts_out_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             periodic;
    logic [TMO_W-1:0] period;
    logic [NOW_W-1:0] deadline;
  } tts_entry_t;

endpackage

// File: hw/rtl/tts_satadd.sv
// Saturating 48-bit deadline adder shared by schedule and periodic reload.
module tts_satadd (
  input  logic [tts_pkg::NOW_W-1:0] a,
  input  logic [tts_pkg::TMO_W-1:0] b,
  output logic [tts_pkg::NOW_W-1:0] sum
);
  import tts_pkg::*;

  logic [NOW_W:0] full;

  assign full = {1'b0, a} + {{(NOW_W - TMO_W + 1){1'b0}}, b};
  assign sum  = full[NOW_W] ? {NOW_W{1'b1}} : full[NOW_W-1:0];

endmodule

// File: hw/rtl/tts_table.sv
// Timer entry memory: one write port, one registered read port.
module tts_table #(
  parameter int DEPTH = tts_pkg::TABLE_SLOTS_DEF,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  tts_pkg::tts_entry_t wr_data,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output tts_pkg::tts_entry_t rd_data
);
  import tts_pkg::*;

  tts_entry_t mem_r [DEPTH];
  tts_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/timer_table_scheduler.sv
// Timer table scheduler top level: sequencer over the entry memory and shared adder.
//
//   port group   | dir | payload      | handshake
//   -------------+-----+--------------+--------------------------
//   in_          | in  | tts_in_t     | in_valid / in_stall
//   out_         | out | tts_out_t    | out_valid / out_stall
//
// Schedule goes through S_SCHED and unknown modes straight to S_FIN; cancel, set_deadline,
// count_due and tick scan the live entries, one memory read per cycle while not held, then S_FIN.
// A tick holds its scan while a fired timer waits behind a stalled result register.
// Synchronous active-low reset empties the table and restarts ids at 1; no clearing pass.
// in_stall is high from a transfer until its final result is loaded.
module timer_table_scheduler #(
  parameter int TABLE_SLOTS = tts_pkg::TABLE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tts_pkg::tts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int NW = $clog2(MAX_FIRE + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCHED = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  tts_in_t          cmd_r, cmd_nxt;
  logic [CW-1:0]    live_r, live_nxt;
  logic [ID_W-1:0]  idc_r, idc_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    w_r, w_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;
  logic             pend_per_r, pend_per_nxt;
  logic             out_valid_r;
  tts_out_t         out_r, out_nxt;
  logic             out_load;

  logic             wr_en, rd_en;
  logic [IW-1:0]    wr_addr, rd_addr;
  tts_entry_t       wr_data, rd_data, entry;
  logic [TMO_W-1:0] add_b;
  logic [NOW_W-1:0] add_sum;
  logic [ID_W-1:0]  new_id;
  logic [CW-1:0]    idx_inc;
  logic             out_free, due, match, fire, keep, hold;
  logic             is_cancel, is_tick, is_count, is_setdl;

  tts_table #(.DEPTH(TABLE_SLOTS), .IW(IW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tts_satadd u_add (
    .a   (cmd_r.now_us),
    .b   (add_b),
    .sum (add_sum)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign is_cancel = (cmd_r.mode == MODE_CANCEL);
  assign is_tick   = (cmd_r.mode == MODE_TICK);
  assign is_count  = (cmd_r.mode == MODE_COUNT);
  assign is_setdl  = (cmd_r.mode == MODE_SETDL);
  assign add_b     = (state_r == S_SCHED) ? cmd_r.timeout_us : rd_data.period;
  assign new_id    = (idc_r == '0) ? ID_W'(1) : idc_r;
  assign idx_inc   = idx_r + CW'(1);

  assign due   = (rd_data.deadline <= cmd_r.now_us);
  assign match = (is_cancel || is_setdl) && !hit_r && (rd_data.id == cmd_r.target_id);
  assign fire  = is_tick && due && (n_r < NW'(MAX_FIRE));
  assign keep  = !(is_cancel && match) && !(fire && !rd_data.periodic);
  // a second fire must push the held one out first
  assign hold  = fire && pend_v_r && !out_free;

  always_comb begin
    entry = rd_data;
    if (is_tick && due && rd_data.periodic) begin
      entry.deadline = add_sum;
    end else if (is_setdl && match) begin
      entry.deadline = cmd_r.new_deadline;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    live_nxt     = live_r;
    idc_nxt      = idc_r;
    idx_nxt      = idx_r;
    w_nxt        = w_r;
    hit_nxt      = hit_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_per_nxt = pend_per_r;
    out_load     = 1'b0;
    out_nxt      = out_r;
    wr_en        = 1'b0;
    wr_addr      = w_r[IW-1:0];
    wr_data      = entry;
    rd_en        = 1'b0;
    rd_addr      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data;
          idx_nxt    = '0;
          w_nxt      = '0;
          hit_nxt    = 1'b0;
          cnt_nxt    = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          if (in_data.mode == MODE_SCHED) begin
            state_nxt = S_SCHED;
          end else if ((in_data.mode inside {MODE_CANCEL, MODE_TICK, MODE_COUNT, MODE_SETDL})
                       && (live_r != '0)) begin
            rd_en     = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCHED: begin
        if (out_free) begin
          out_load = 1'b1;
          if (live_r == CW'(TABLE_SLOTS)) begin
            out_nxt = '{status: STAT_FULL, result_id: '0, fired_periodic: 1'b0,
                        due_cnt: '0, last: 1'b1};
          end else begin
            wr_en    = 1'b1;
            wr_addr  = live_r[IW-1:0];
            wr_data  = '{id: new_id, periodic: cmd_r.periodic,
                         period: cmd_r.timeout_us, deadline: add_sum};
            live_nxt = live_r + CW'(1);
            idc_nxt  = (new_id >= ID_MAX) ? ID_W'(1) : new_id + ID_W'(1);
            out_nxt  = '{status: STAT_OK, result_id: new_id, fired_periodic: 1'b0,
                         due_cnt: '0, last: 1'b1};
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!hold) begin
          if (keep) begin
            wr_en = !is_count;
            w_nxt = w_r + CW'(1);
          end
          if (match) begin
            hit_nxt = 1'b1;
          end
          if (is_count && due && (cnt_r != DUE_SAT)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (fire) begin
            if (pend_v_r) begin
              out_load = 1'b1;
              out_nxt  = '{status: STAT_OK, result_id: pend_id_r,
                           fired_periodic: pend_per_r, due_cnt: '0, last: 1'b0};
            end
            pend_v_nxt   = 1'b1;
            pend_id_nxt  = rd_data.id;
            pend_per_nxt = rd_data.periodic;
            n_nxt        = n_r + NW'(1);
          end
          idx_nxt = idx_inc;
          if (idx_inc < live_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[IW-1:0];
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '{status: STAT_OK, result_id: '0, fired_periodic: 1'b0,
                       due_cnt: '0, last: 1'b1};
          case (cmd_r.mode)
            MODE_CANCEL, MODE_SETDL: begin
              out_nxt.status = hit_r ? STAT_OK : STAT_NOTFOUND;
            end
            MODE_COUNT: begin
              out_nxt.due_cnt = cnt_r;
            end
            MODE_TICK: begin
              if (pend_v_r) begin
                out_nxt.result_id      = pend_id_r;
                out_nxt.fired_periodic = pend_per_r;
              end else begin
                out_nxt.status = STAT_NONE;
              end
            end
            default: begin
            end
          endcase
          if (is_cancel || is_tick) begin
            live_nxt = w_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      idc_r       <= ID_W'(1);
      idx_r       <= '0;
      w_r         <= '0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      live_r   <= live_nxt;
      idc_r    <= idc_nxt;
      idx_r    <= idx_nxt;
      w_r      <= w_nxt;
      hit_r    <= hit_nxt;
      cnt_r    <= cnt_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_per_r <= pend_per_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(TABLE_SLOTS))
    else $error("live count above table size");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((idx_r < live_r) && (w_r <= idx_r)))
    else $error("scan index out of range or write ahead of read");

  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r == (n_r != '0))
    else $error("held fire and fire count disagree");

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_FIRE))
    else $error("fire count above cap");

  a_sched_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCHED && out_free && live_r != CW'(TABLE_SLOTS))
      |=> (live_r == $past(live_r) + CW'(1)))
    else $error("schedule did not add an entry");

endmodule
